>>> sv/tapd_pkg.sv
// Shared types, constants and the microcode table of the two-axis PID drive.
`timescale 1ns / 1ps

package tapd_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int unsigned DUTY_FULL_SCALE_DEF = 400;
  localparam int unsigned INTEGRAL_WIDTH_DEF  = 48;

  // Fixed-point format and duty clamp limits
  localparam int unsigned Q_SHIFT = 24;
  localparam int unsigned U_CEIL  = 255;
  localparam int unsigned U_FLOOR = 50;

  // Control sum width: covers kp*e + kd*de + capped ki*sum with margin
  localparam int unsigned ACC_W = 63;

  // Gain and tolerance values after reset
  localparam logic [31:0] GAIN_P_X_RST = 32'd335544320;
  localparam logic [31:0] GAIN_I_X_RST = 32'd168;
  localparam logic [31:0] GAIN_D_X_RST = 32'd134217728;
  localparam logic [31:0] GAIN_P_Y_RST = 32'd335544320;
  localparam logic [31:0] GAIN_I_Y_RST = 32'd17;
  localparam logic [31:0] GAIN_D_Y_RST = 32'd1678;
  localparam logic [7:0]  TOL_RST      = 8'd2;

  // Sequencer sizing
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned NUM_STEPS = 12;

  // Register map of the configuration port
  typedef enum logic [2:0] {
    CFG_GAIN_P_X   = 3'd0,
    CFG_GAIN_I_X   = 3'd1,
    CFG_GAIN_D_X   = 3'd2,
    CFG_GAIN_P_Y   = 3'd3,
    CFG_GAIN_I_Y   = 3'd4,
    CFG_GAIN_D_Y   = 3'd5,
    CFG_TOLERANCE  = 3'd6
  } cfg_idx_t;

  // Drive direction codes
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  // Request payloads
  typedef struct packed {
    logic               axis;
    logic signed [15:0] target_position;
    logic signed [15:0] current_position;
  } in_item_t;

  typedef struct packed {
    logic       axis_out;
    logic [1:0] drive_direction;
    logic [8:0] duty;
    logic       settled;
  } out_item_t;

  // Configuration set seen by the datapath
  typedef struct packed {
    logic [1:0][31:0] gain_p;
    logic [1:0][31:0] gain_i;
    logic [1:0][31:0] gain_d;
    logic [7:0]       tolerance;
  } gains_t;

  // Microcode fields
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_P_E,
    MUL_D_DE,
    MUL_I_HI,
    MUL_I_LO,
    MUL_M_FS,
    MUL_Q_RECIP
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_ISAT
  } acc_op_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAG,
    OP_PH,
    OP_CAP,
    OP_ABS,
    OP_Q1,
    OP_FIX,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    cond_t             cond;
    logic              jmp;
    logic [STEP_W-1:0] target;
    mul_sel_t          mul_sel;
    acc_op_t           acc_op;
    dp_op_t            dp_op;
  } uword_t;

  // Control word as driven into the datapath; go marks a step that fires
  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    dp_op_t   dp_op;
    logic     go;
  } ctl_t;

  // Microprogram: one control word per step
  function automatic uword_t ucode(input logic [STEP_W-1:0] s);
    uword_t w;
    w.cond    = COND_ALWAYS;
    w.jmp     = 1'b0;
    w.target  = '0;
    w.mul_sel = MUL_NONE;
    w.acc_op  = ACC_NONE;
    w.dp_op   = OP_NONE;
    unique case (s)
      4'd0: begin
        // take a request, update error and integral
        w.cond  = COND_IN_VALID;
        w.dp_op = OP_LOAD;
      end
      4'd1: begin
        w.mul_sel = MUL_P_E;
        w.dp_op   = OP_MAG;
      end
      4'd2: begin
        w.mul_sel = MUL_D_DE;
        w.acc_op  = ACC_LOAD;
      end
      4'd3: begin
        w.mul_sel = MUL_I_HI;
        w.acc_op  = ACC_ADD;
      end
      4'd4: begin
        w.mul_sel = MUL_I_LO;
        w.dp_op   = OP_PH;
      end
      4'd5: begin
        w.dp_op = OP_CAP;
      end
      4'd6: begin
        w.acc_op = ACC_ADD_ISAT;
      end
      4'd7: begin
        w.dp_op = OP_ABS;
      end
      4'd8: begin
        w.mul_sel = MUL_M_FS;
      end
      4'd9: begin
        w.mul_sel = MUL_Q_RECIP;
        w.dp_op   = OP_Q1;
      end
      4'd10: begin
        w.dp_op = OP_FIX;
      end
      4'd11: begin
        // hand the result to the output register, then start over
        w.cond  = COND_OUT_FREE;
        w.dp_op = OP_EMIT;
        w.jmp   = 1'b1;
      end
      default: begin
        w.jmp = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

>>> sv/tapd_mul.sv
// Shared registered multiplier: unsigned 32-bit by signed 33-bit.
`timescale 1ns / 1ps

module tapd_mul import tapd_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         mul_a,
  input  logic signed [32:0]  mul_b,
  output logic signed [64:0]  prod_r
);

  logic signed [65:0] prod_nxt;

  // Form the full product; the top bit only repeats the sign
  assign prod_nxt = $signed({1'b0, mul_a}) * mul_b;

  // Hold the product until the next multiply step
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt[64:0];
    end
  end

endmodule

>>> sv/tapd_useq.sv
// Microcode sequencer: step counter, control word table and jump logic.
`timescale 1ns / 1ps

module tapd_useq import tapd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_free,
  output logic in_ready,
  output ctl_t ctl
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  uword_t            uw;
  logic              go;

  assign uw = ucode(step_r);

  // Evaluate the step condition; take no request while reset is held
  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:   go = 1'b1;
      COND_IN_VALID: go = in_valid & rst_n;
      COND_OUT_FREE: go = out_free;
      default:       go = 1'b0;
    endcase
  end

  // Advance, jump or hold the step counter
  always_comb begin
    priority if (!go) begin
      step_nxt = step_r;
    end else if (uw.jmp) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign in_ready    = rst_n & (uw.cond == COND_IN_VALID);
  assign ctl.mul_sel = uw.mul_sel;
  assign ctl.acc_op  = uw.acc_op;
  assign ctl.dp_op   = uw.dp_op;
  assign ctl.go      = go;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < STEP_W'(NUM_STEPS))
    else $error("step counter outside the microprogram");

  a_accept_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (step_r == STEP_W'(1)))
    else $error("accepted request did not start the program");

  a_ready_only_at_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (uw.dp_op == OP_LOAD))
    else $error("ready raised outside the load step");
`endif

endmodule

>>> sv/tapd_dpath.sv
// PID datapath: per-axis state, error, integral, control sum and duty scaling.
`timescale 1ns / 1ps

module tapd_dpath import tapd_pkg::*; #(
  parameter int unsigned DUTY_FULL_SCALE = DUTY_FULL_SCALE_DEF,
  parameter int unsigned INTEGRAL_WIDTH  = INTEGRAL_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_t      ctl,
  input  gains_t    gains,
  input  in_item_t  in_item,
  output out_item_t res
);

  localparam int unsigned IW = INTEGRAL_WIDTH;
  // Width of floor(m * full scale / 2^24) in the unclamped band
  localparam int unsigned QW = $clog2(256 * DUTY_FULL_SCALE);
  // Reciprocal of 255 for the final divide
  localparam int unsigned RS = QW + 8;
  localparam logic [63:0] RECIP = (64'd1 << RS) / 64'd255;
  localparam logic [31:0] DUTY_CEIL_V  = 32'(DUTY_FULL_SCALE);
  localparam logic [31:0] DUTY_FLOOR_V = 32'(U_FLOOR * DUTY_FULL_SCALE / U_CEIL);
  localparam logic [ACC_W-1:0] M_CEIL  = ACC_W'(U_CEIL) << Q_SHIFT;
  localparam logic [ACC_W-1:0] M_FLOOR = ACC_W'(U_FLOOR) << Q_SHIFT;
  localparam logic [IW-1:0] SUM_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic [IW-1:0] SUM_MIN = {1'b1, {(IW-1){1'b0}}};
  localparam logic [60:0] P_CAP = 61'd1 << 60;

  // Per-axis state
  logic [1:0][IW-1:0] sum_r;
  logic [1:0][15:0]   prev_r;

  // Working registers for the request in flight
  logic              axis_r;
  logic [15:0]       e_r;
  logic [16:0]       de_r;
  logic              settled_r;
  logic [IW-1:0]     sum_cur_r;
  logic [63:0]       imag_r;
  logic              isneg_r;
  logic              ph_big_r;
  logic [27:0]       ph_lo_r;
  logic [ACC_W-1:0]  isat_r;
  logic [ACC_W-1:0]  acc_r;
  logic [31:0]       m_lo_r;
  logic              ceil_r;
  logic              floor_r;
  logic              pos_r;
  logic [QW-1:0]     q1_r;
  logic [8:0]        duty_mid_r;

  // Multiplier hookup
  logic               mul_en;
  logic [31:0]        mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] prod_r;

  // Load-step logic
  logic [16:0]   diff;
  logic [15:0]   e_sat;
  logic [16:0]   e_ext;
  logic [16:0]   e_abs;
  logic [IW-1:0] s_old;
  logic [IW:0]   s_wide;
  logic [IW-1:0] s_new;
  logic [16:0]   de_new;
  logic          settled_new;

  // Later-step logic
  logic [IW-1:0]    smag;
  logic [60:0]      p_sum;
  logic             p_cap;
  logic [60:0]      p_val;
  logic [ACC_W-1:0] p_ext;
  logic [ACC_W-1:0] m_abs;
  logic [QW-1:0]    q1_w;
  logic [QW-1:0]    q0;
  logic [QW+7:0]    q0x255;
  logic [QW+7:0]    rem;
  logic [QW-1:0]    q_fix;

  tapd_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // Select multiplier operands
  always_comb begin
    mul_en = 1'b1;
    unique case (ctl.mul_sel)
      MUL_P_E: begin
        mul_a = gains.gain_p[axis_r];
        mul_b = {{17{e_r[15]}}, e_r};
      end
      MUL_D_DE: begin
        mul_a = gains.gain_d[axis_r];
        mul_b = {{16{de_r[16]}}, de_r};
      end
      MUL_I_HI: begin
        mul_a = gains.gain_i[axis_r];
        mul_b = {1'b0, imag_r[63:32]};
      end
      MUL_I_LO: begin
        mul_a = gains.gain_i[axis_r];
        mul_b = {1'b0, imag_r[31:0]};
      end
      MUL_M_FS: begin
        mul_a = m_lo_r;
        mul_b = 33'(DUTY_FULL_SCALE);
      end
      MUL_Q_RECIP: begin
        mul_a = RECIP[31:0];
        mul_b = 33'(q1_w);
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  // Saturated error, saturating integral, error change, tolerance test
  always_comb begin
    diff   = {in_item.target_position[15], in_item.target_position}
           - {in_item.current_position[15], in_item.current_position};
    e_sat  = (diff[16] != diff[15]) ? {diff[16], {15{~diff[16]}}} : diff[15:0];
    e_ext  = {e_sat[15], e_sat};
    e_abs  = e_ext[16] ? (17'd0 - e_ext) : e_ext;
    s_old  = sum_r[in_item.axis];
    s_wide = {s_old[IW-1], s_old} + {{(IW-15){e_sat[15]}}, e_sat};
    if (s_wide[IW] != s_wide[IW-1]) begin
      s_new = s_wide[IW] ? SUM_MIN : SUM_MAX;
    end else begin
      s_new = s_wide[IW-1:0];
    end
    de_new      = e_ext - {prev_r[in_item.axis][15], prev_r[in_item.axis]};
    settled_new = (e_abs <= {9'd0, gains.tolerance});
  end

  // Integral magnitude, capped integral product, control magnitude
  always_comb begin
    smag  = sum_cur_r[IW-1] ? (IW'(0) - sum_cur_r) : sum_cur_r;
    p_sum = {1'b0, ph_lo_r, 32'd0} + {1'b0, prod_r[59:0]};
    p_cap = ph_big_r | (|prod_r[64:60]) | (p_sum > P_CAP);
    p_val = p_cap ? P_CAP : p_sum;
    p_ext = ACC_W'(p_val);
    m_abs = acc_r[ACC_W-1] ? (ACC_W'(0) - acc_r) : acc_r;
  end

  // Divide by 255 through the reciprocal, then correct by one
  always_comb begin
    q1_w   = prod_r[Q_SHIFT +: QW];
    q0     = prod_r[RS +: QW];
    q0x255 = {q0, 8'd0} - {8'd0, q0};
    rem    = {8'd0, q1_r} - q0x255;
    q_fix  = q0 + QW'(rem >= (QW+8)'(U_CEIL));
  end

  // Update per-axis state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      prev_r <= '0;
    end else if (ctl.dp_op == OP_LOAD && ctl.go) begin
      sum_r[in_item.axis]  <= s_new;
      prev_r[in_item.axis] <= e_sat;
    end
  end

  // Step the working registers
  always_ff @(posedge clk) begin
    unique case (ctl.dp_op)
      OP_LOAD: begin
        if (ctl.go) begin
          axis_r    <= in_item.axis;
          e_r       <= e_sat;
          de_r      <= de_new;
          settled_r <= settled_new;
          sum_cur_r <= s_new;
        end
      end
      OP_MAG: begin
        imag_r  <= 64'(smag);
        isneg_r <= sum_cur_r[IW-1];
      end
      OP_PH: begin
        ph_big_r <= |prod_r[64:28];
        ph_lo_r  <= prod_r[27:0];
      end
      OP_CAP: begin
        isat_r <= isneg_r ? (ACC_W'(0) - p_ext) : p_ext;
      end
      OP_ABS: begin
        m_lo_r  <= m_abs[31:0];
        ceil_r  <= (m_abs > M_CEIL);
        floor_r <= (m_abs < M_FLOOR);
        pos_r   <= ~acc_r[ACC_W-1] && (acc_r != '0);
      end
      OP_Q1: begin
        q1_r <= q1_w;
      end
      OP_FIX: begin
        duty_mid_r <= q_fix[8:0];
      end
      default: begin
      end
    endcase
  end

  // Accumulate the control sum
  always_ff @(posedge clk) begin
    unique case (ctl.acc_op)
      ACC_LOAD:     acc_r <= prod_r[ACC_W-1:0];
      ACC_ADD:      acc_r <= acc_r + prod_r[ACC_W-1:0];
      ACC_ADD_ISAT: acc_r <= acc_r + isat_r;
      default:      acc_r <= acc_r;
    endcase
  end

  // Assemble the drive command
  always_comb begin
    res.axis_out = axis_r;
    res.settled  = settled_r;
    priority if (settled_r) begin
      res.drive_direction = DIR_STOP;
      res.duty            = '0;
    end else begin
      res.drive_direction = pos_r ? DIR_CW : DIR_CCW;
      priority if (ceil_r) begin
        res.duty = DUTY_CEIL_V[8:0];
      end else if (floor_r) begin
        res.duty = DUTY_FLOOR_V[8:0];
      end else begin
        res.duty = duty_mid_r;
      end
    end
  end

endmodule

>>> sv/two_axis_pid_position_drive_core.sv
// Top level of the two-axis PID position drive: ports, gain registers, output register.
// Each request runs a 12-step microprogram on one shared 32x33 multiplier.
// The result is loaded into the output register at the last step, which waits while the output is stalled.
// A new request is taken only after the previous result has been handed to the output register.
// Synchronous active-low reset restores default gains and tolerance,
// clears both axes' integral and previous error, and empties the output.
`timescale 1ns / 1ps

module two_axis_pid_position_drive_core import tapd_pkg::*; #(
  parameter int unsigned DUTY_FULL_SCALE = DUTY_FULL_SCALE_DEF,
  parameter int unsigned INTEGRAL_WIDTH  = INTEGRAL_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  gains_t    gains_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_free;
  logic      emit;
  ctl_t      ctl;
  out_item_t res;

  assign cfg_ready = rst_n;
  assign out_free  = ~out_valid_r | out_ready;
  assign emit      = (ctl.dp_op == OP_EMIT) && ctl.go;

  tapd_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  tapd_dpath #(
    .DUTY_FULL_SCALE (DUTY_FULL_SCALE),
    .INTEGRAL_WIDTH  (INTEGRAL_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .gains   (gains_r),
    .in_item (in_data),
    .res     (res)
  );

  // Write gain and tolerance registers; drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.gain_p    <= {GAIN_P_Y_RST, GAIN_P_X_RST};
      gains_r.gain_i    <= {GAIN_I_Y_RST, GAIN_I_X_RST};
      gains_r.gain_d    <= {GAIN_D_Y_RST, GAIN_D_X_RST};
      gains_r.tolerance <= TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN_P_X:  gains_r.gain_p[0]  <= cfg_data;
        CFG_GAIN_I_X:  gains_r.gain_i[0]  <= cfg_data;
        CFG_GAIN_D_X:  gains_r.gain_d[0]  <= cfg_data;
        CFG_GAIN_P_Y:  gains_r.gain_p[1]  <= cfg_data;
        CFG_GAIN_I_Y:  gains_r.gain_i[1]  <= cfg_data;
        CFG_GAIN_D_Y:  gains_r.gain_d[1]  <= cfg_data;
        CFG_TOLERANCE: gains_r.tolerance  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Output register: load on emit, drop on downstream accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_valid_r) |-> out_ready)
    else $error("result emitted over an unaccepted one");

  a_settled_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.settled) |->
      (out_data_r.drive_direction == DIR_STOP && out_data_r.duty == 9'd0))
    else $error("settled result still drives the motor");

  a_moving_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.settled) |->
      (out_data_r.drive_direction == DIR_CW || out_data_r.drive_direction == DIR_CCW))
    else $error("unsettled result without a direction");
`endif

endmodule
